// File: sv/hkm_pkg.sv
// ----------------------------------------------------------------------------
// hkm_pkg
// Types and constants shared by the HID report to key matrix block.
// ----------------------------------------------------------------------------
package hkm_pkg;

   localparam int ROWS      = 8;
   localparam int MAX_SLOTS = 6;

   typedef logic [ROWS-1:0][7:0] matrix_type;

   // function codes of the request word
   localparam logic [1:0] FUNC_REPORT = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_ACK    = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [7:0] MOD_LSHIFT_MASK = 8'h02;
   localparam logic [7:0] SHIFT_CLR_MASK  = 8'hfc;

   // HID usage codes
   localparam logic [7:0] HK_A      = 8'h04;
   localparam logic [7:0] HK_Z      = 8'h1d;
   localparam logic [7:0] HK_1      = 8'h1e;
   localparam logic [7:0] HK_2      = 8'h1f;
   localparam logic [7:0] HK_6      = 8'h23;
   localparam logic [7:0] HK_7      = 8'h24;
   localparam logic [7:0] HK_8      = 8'h25;
   localparam logic [7:0] HK_9      = 8'h26;
   localparam logic [7:0] HK_0      = 8'h27;
   localparam logic [7:0] HK_ENTER  = 8'h28;
   localparam logic [7:0] HK_ESC    = 8'h29;
   localparam logic [7:0] HK_BKSP   = 8'h2a;
   localparam logic [7:0] HK_SPACE  = 8'h2c;
   localparam logic [7:0] HK_MINUS  = 8'h2d;
   localparam logic [7:0] HK_EQUAL  = 8'h2e;
   localparam logic [7:0] HK_SEMI   = 8'h33;
   localparam logic [7:0] HK_APOS   = 8'h34;
   localparam logic [7:0] HK_COMMA  = 8'h36;
   localparam logic [7:0] HK_DOT    = 8'h37;
   localparam logic [7:0] HK_SLASH  = 8'h38;
   localparam logic [7:0] HK_F1     = 8'h3a;
   localparam logic [7:0] HK_RIGHT  = 8'h4f;
   localparam logic [7:0] HK_LEFT   = 8'h50;
   localparam logic [7:0] HK_DOWN   = 8'h51;
   localparam logic [7:0] HK_UP     = 8'h52;
   localparam logic [7:0] HK_LCTRL  = 8'he0;
   localparam logic [7:0] HK_LSHIFT = 8'he1;
   localparam logic [7:0] HK_RCTRL  = 8'he4;
   localparam logic [7:0] HK_RSHIFT = 8'he5;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] modifiers;
      logic [7:0] key_a;
      logic [7:0] key_b;
      logic [7:0] key_c;
      logic [7:0] key_d;
      logic [7:0] key_e;
      logic [7:0] key_f;
      logic [7:0] read_addr;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       changed;
      logic       dirty_out;
   } rsp_word_type;

   // decode of one key: matrix bits it presses and whether it drops shift
   typedef struct packed {
      matrix_type rows;
      logic       shift_clr;
   } key_dec_type;

endpackage

// File: sv/hkm_if.sv
// ----------------------------------------------------------------------------
// hkm_req_if / hkm_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface hkm_req_if import hkm_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hkm_rsp_if import hkm_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/hkm_key_decode.sv
// ----------------------------------------------------------------------------
// hkm_key_decode
// Maps one HID usage code, with the shift state, to the matrix bits it presses and whether it drops shift.
// ----------------------------------------------------------------------------
module hkm_key_decode import hkm_pkg::*; (
   input  logic [7:0]  key,
   input  logic        shift,
   output key_dec_type dec
);

   logic [4:0] let_pos;
   logic [3:0] dig_pos;
   matrix_type m;
   logic       clr;

   assign let_pos = 5'(key - 8'd3);   // A lands on position 1
   assign dig_pos = 4'(key - 8'd29);  // 1 lands on position 1

   always_comb begin
      m   = '0;
      clr = 1'b0;
      if (key >= HK_A && key <= HK_Z) begin
         m[{1'b0, let_pos[4:3]}][let_pos[2:0]] = 1'b1;
      end else if (key == HK_2 && shift) begin
         m[0][0] = 1'b1;
         clr     = 1'b1;
      end else if (key == HK_6 && shift) begin
         clr = 1'b1;
      end else if (key == HK_7 && shift) begin
         m[4][6] = 1'b1;
      end else if (key == HK_8 && shift) begin
         m[5][2] = 1'b1;
      end else if (key == HK_9 && shift) begin
         m[5][0] = 1'b1;
         m[7][0] = 1'b1;
      end else if (key == HK_0 && shift) begin
         m[5][1] = 1'b1;
         m[7][0] = 1'b1;
      end else if (key >= HK_1 && key <= HK_9) begin
         m[{2'b10, dig_pos[3]}][dig_pos[2:0]] = 1'b1;
      end else if (key == HK_0) begin
         m[4][0] = 1'b1;
      end else if (key == HK_SEMI && !shift) begin
         m[5][3] = 1'b1;
         clr     = 1'b1;
      end else if (key == HK_SEMI) begin
         m[5][2] = 1'b1;
         clr     = 1'b1;
      end else if (key == HK_APOS && shift) begin
         m[4][2] = 1'b1;
         m[7][0] = 1'b1;
      end else if (key == HK_COMMA) begin
         m[5][4] = 1'b1;
      end else if (key == HK_DOT) begin
         m[5][6] = 1'b1;
      end else if (key == HK_EQUAL && !shift) begin
         m[5][5] = 1'b1;
         m[7][0] = 1'b1;
      end else if (key == HK_EQUAL) begin
         m[5][3] = 1'b1;
         m[7][0] = 1'b1;
      end else if (key == HK_MINUS && !shift) begin
         m[5][5] = 1'b1;
         clr     = 1'b1;
      end else if (key == HK_SLASH) begin
         m[5][7] = 1'b1;
      end else if (key == HK_ENTER) begin
         m[6][0] = 1'b1;
      end else if (key == HK_BKSP || key == HK_LEFT) begin
         m[6][5] = 1'b1;
      end else if (key == HK_ESC) begin
         m[6][2] = 1'b1;
      end else if (key == HK_UP) begin
         m[6][3] = 1'b1;
      end else if (key == HK_DOWN) begin
         m[6][4] = 1'b1;
      end else if (key == HK_RIGHT) begin
         m[6][6] = 1'b1;
      end else if (key == HK_SPACE) begin
         m[6][7] = 1'b1;
      end else if (key == HK_F1) begin
         m[6][1] = 1'b1;
      end else if (key == HK_LSHIFT) begin
         m[7][0] = 1'b1;
      end else if (key == HK_RSHIFT) begin
         m[7][1] = 1'b1;
      end else if (key == HK_LCTRL || key == HK_RCTRL) begin
         m[7][4] = 1'b1;
      end
   end

   assign dec.rows      = m;
   assign dec.shift_clr = clr;

endmodule

// File: sv/hid_report_to_key_matrix.sv
// ----------------------------------------------------------------------------
// hid_report_to_key_matrix
// Keyboard matrix emulation of an 8-row home computer fed by HID reports.
// ----------------------------------------------------------------------------
// Request channel req_chan carries one word per item: func selects a key
// report (decode up to six usage codes plus the shift modifier into the
// eight row bytes), a matrix read (OR of the rows whose bits are set in
// read_addr) or an acknowledge (return and clear the dirty flag).
// Response channel rsp_chan returns exactly one word per request, in order.
// Each request passes the input register, then the response register, and one
// word per cycle is sustained while the receiver takes every response. The
// work runs between the input register and the response register; the row
// bytes and dirty flag update as a word leaves the input register, so a
// following request always sees the prior one.
// When the receiver stalls, the response register holds and the input
// register fills; req_chan.ready then drops until the response is taken.
// Reset (synchronous) clears the rows, sets the dirty flag and empties both
// registers. KEY_SLOTS (1..6) sets how many key slots of a report count.
// ----------------------------------------------------------------------------
module hid_report_to_key_matrix import hkm_pkg::*; #(
   parameter int KEY_SLOTS = 6
) (
   input logic      clock,
   input logic      reset,
   hkm_req_if.sink   req_chan,
   hkm_rsp_if.source rsp_chan
);

   logic         s1_vld_ff, s1_vld_in;
   req_word_type s1_word_ff;
   logic         out_vld_ff, out_vld_in;
   rsp_word_type out_word_ff, out_word_in;
   matrix_type   rows_ff, rows_in;
   logic         dirty_ff, dirty_in;

   logic         advance;
   logic [7:0]   keys [MAX_SLOTS];
   key_dec_type  dec  [MAX_SLOTS];
   matrix_type   new_rows;
   logic         shift_clr;
   logic         shift_on;
   logic         rows_diff;
   logic [7:0]   rd_data;

   // move stage one forward when the response register is free or drains
   assign advance        = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_vld_ff || advance;
   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.payload = out_word_ff;

   assign shift_on = (s1_word_ff.modifiers & MOD_LSHIFT_MASK) != 8'd0;

   assign keys[0] = s1_word_ff.key_a;
   assign keys[1] = s1_word_ff.key_b;
   assign keys[2] = s1_word_ff.key_c;
   assign keys[3] = s1_word_ff.key_d;
   assign keys[4] = s1_word_ff.key_e;
   assign keys[5] = s1_word_ff.key_f;

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
      if (i < KEY_SLOTS) begin : g_used
         hkm_key_decode u_dec (
            .key   (keys[i]),
            .shift (shift_on),
            .dec   (dec[i])
         );
      end else begin : g_unused
         assign dec[i] = '0;
      end
   end

   always_comb begin
      new_rows  = '0;
      shift_clr = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         new_rows  = new_rows | dec[i].rows;
         shift_clr = shift_clr | dec[i].shift_clr;
      end
      if (shift_clr) begin
         new_rows[ROWS-1] = new_rows[ROWS-1] & SHIFT_CLR_MASK;
      end
   end

   assign rows_diff = new_rows != rows_ff;

   always_comb begin
      rd_data = '0;
      for (int r = 0; r < ROWS; r++) begin
         if (s1_word_ff.read_addr[r]) begin
            rd_data = rd_data | rows_ff[r];
         end
      end
   end

   always_comb begin
      rows_in     = rows_ff;
      dirty_in    = dirty_ff;
      out_vld_in  = out_vld_ff;
      out_word_in = out_word_ff;
      s1_vld_in   = s1_vld_ff;
      // load stage one whenever it can take a word
      if (req_chan.ready) begin
         s1_vld_in = req_chan.valid;
      end
      if (advance) begin
         out_vld_in = s1_vld_ff;
         out_word_in.read_data = '0;
         out_word_in.changed   = 1'b0;
         out_word_in.dirty_out = dirty_ff;
         unique case (s1_word_ff.func)
            FUNC_REPORT: begin
               out_word_in.changed   = rows_diff;
               out_word_in.dirty_out = dirty_ff | rows_diff;
               if (s1_vld_ff) begin
                  rows_in  = new_rows;
                  dirty_in = dirty_ff | rows_diff;
               end
            end
            FUNC_READ: begin
               out_word_in.read_data = rd_data;
            end
            FUNC_ACK: begin
               if (s1_vld_ff) begin
                  dirty_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         rows_ff    <= '0;
         dirty_ff   <= 1'b1;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         rows_ff    <= rows_in;
         dirty_ff   <= dirty_in;
      end
   end

   // payload registers: the input word captures on acceptance and holds otherwise; the response word loads on advance
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_word_ff <= req_chan.payload;
      end
      out_word_ff <= out_word_in;
   end

endmodule
